### design/nmf3_pkg.sv
// ----------------------------------------------------------------------------
// nmf3_pkg
// Shared types and constants of the 3x3 neighbour median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nmf3_pkg;

	// channel and field widths
	localparam int PIX_W      = 8;
	localparam int WORD_W     = 4 * PIX_W;   // packed RGBA: R low byte, A high byte
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 16;
	localparam int ROW_W      = 16;
	localparam int COL_OUT_W  = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// sizes
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int WIDTH_RST     = 640;
	localparam int HEIGHT_RST    = 480;
	localparam int MIN_SIZE      = 3;
	localparam int NEIGH_N       = 8;
	localparam int MED_RANK      = 4;        // fifth smallest, counted from zero

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// window slots holding the eight neighbours (centre slot 4 left out)
	localparam logic [3:0] NBR_POS [NEIGH_N] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8
	};

	// position status of the pixel being accepted
	typedef struct packed {
		logic             emit;   // window centre is interior
		logic             last;   // centre is last interior pixel of frame
		logic [ROW_W-1:0] row;    // row of the incoming pixel
	} pos_info_t;

endpackage

`default_nettype wire

### design/nmf3_linebuf.sv
// ----------------------------------------------------------------------------
// nmf3_linebuf
// Two line stores side by side: upper row in the high word, middle row low.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf3_linebuf #(
	parameter int MAX_WIDTH = nmf3_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int DW = 2 * nmf3_pkg::WORD_W
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read returns the old entry on a same-edge write; top level forwards
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/nmf3_position.sv
// ----------------------------------------------------------------------------
// nmf3_position
// Size registers and raster column/row counters.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf3_position #(
	parameter int MAX_WIDTH = nmf3_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [nmf3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [nmf3_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                accept,
	input  wire logic                                frame_start,
	output logic      [AW-1:0]                       col,
	output nmf3_pkg::pos_info_t                      info
);

	localparam int RW = nmf3_pkg::ROW_W;
	localparam int W_RST_EFF = (nmf3_pkg::WIDTH_RST > MAX_WIDTH) ?
		MAX_WIDTH : nmf3_pkg::WIDTH_RST;
	localparam logic [AW-1:0] WLAST_RST = AW'(W_RST_EFF - 1);
	localparam logic [RW-1:0] HLAST_RST = RW'(nmf3_pkg::HEIGHT_RST - 1);

	logic [AW-1:0] wlast_q;   // effective width - 1
	logic [RW-1:0] hlast_q;   // effective height - 1
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [nmf3_pkg::IMG_W_W-1:0] w_raw;
	logic [nmf3_pkg::IMG_H_W-1:0] h_raw;
	logic [AW-1:0]                wlast_d;
	logic [RW-1:0]                hlast_d;
	logic [AW-1:0]                c;
	logic [RW-1:0]                r;

	// clamp written sizes
	always_comb begin
		w_raw = cfg_data[nmf3_pkg::IMG_W_W-1:0];
		h_raw = cfg_data[nmf3_pkg::IMG_H_W-1:0];
		if (w_raw < nmf3_pkg::IMG_W_W'(nmf3_pkg::MIN_SIZE)) begin
			wlast_d = AW'(nmf3_pkg::MIN_SIZE - 1);
		end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
			wlast_d = AW'(MAX_WIDTH - 1);
		end else begin
			wlast_d = AW'(w_raw - nmf3_pkg::IMG_W_W'(1));
		end
		if (h_raw < nmf3_pkg::IMG_H_W'(nmf3_pkg::MIN_SIZE)) begin
			hlast_d = RW'(nmf3_pkg::MIN_SIZE - 1);
		end else begin
			hlast_d = RW'(h_raw - nmf3_pkg::IMG_H_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= WLAST_RST;
			hlast_q <= HLAST_RST;
		end else if (cfg_wr_en) begin
			case (nmf3_pkg::cfg_reg_t'(cfg_index))
				nmf3_pkg::REG_IMAGE_WIDTH: begin
					wlast_q <= wlast_d;
				end
				nmf3_pkg::REG_IMAGE_HEIGHT: begin
					hlast_q <= hlast_d;
				end
				default: begin
				end
			endcase
		end
	end

	// position of the incoming pixel, with wrap after a mid-frame shrink
	always_comb begin
		c = frame_start ? '0 : col_q;
		r = frame_start ? '0 : row_q;
		if (c > wlast_q) begin
			c = '0;
			r = r + RW'(1);
		end
		if (r > hlast_q) begin
			r = '0;
		end
		col       = c;
		info.row  = r;
		info.emit = (r >= RW'(2)) && (c >= AW'(2));
		info.last = (r == hlast_q) && (c == wlast_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c >= wlast_q) begin
				col_q <= '0;
				row_q <= (r >= hlast_q) ? '0 : r + RW'(1);
			end else begin
				col_q <= c + AW'(1);
				row_q <= r;
			end
		end
	end

endmodule

`default_nettype wire

### design/nmf3_median.sv
// ----------------------------------------------------------------------------
// nmf3_median
// Fifth smallest of eight bytes by rank counting (ties broken by slot).
// ----------------------------------------------------------------------------
`default_nettype none

module nmf3_median (
	input  wire logic [nmf3_pkg::NEIGH_N-1:0][nmf3_pkg::PIX_W-1:0] nbr,
	output logic      [nmf3_pkg::PIX_W-1:0]                        med
);

	localparam int N = nmf3_pkg::NEIGH_N;

	logic [2:0]                 rank [N];
	logic [N-1:0]               hit;

	// rank of slot i = values strictly below it plus equal values in lower slots
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rank[i] = '0;
			for (int j = 0; j < N; j++) begin
				if (j != i) begin
					if ((nbr[j] < nbr[i]) || ((j < i) && (nbr[j] == nbr[i]))) begin
						rank[i] = rank[i] + 3'd1;
					end
				end
			end
			hit[i] = (rank[i] == 3'(nmf3_pkg::MED_RANK));
		end
	end

	// ranks form a permutation, so exactly one slot hits
	always_comb begin
		med = '0;
		for (int i = 0; i < N; i++) begin
			med = med | (hit[i] ? nbr[i] : '0);
		end
	end

endmodule

`default_nettype wire

### design/neighbour_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// neighbour_median_filter_3x3
// 3x3 neighbour median filter on an RGBA raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one word per clock when both sides keep up.
// For every pixel whose window centre is interior, one result word leaves:
// red, green and blue are the fifth smallest of the eight pixels around the
// centre (centre left out), alpha is the centre's alpha, and out_row/out_col
// give the centre position; frame_last flags the last interior centre. Border
// rows and columns give nothing. frame_start restarts the counters at row 0,
// column 0. Sizes come from the config port (index 0 width, 1 height); width
// is clamped to 3..MAX_WIDTH, height to at least 3; write them only while idle.
// Throughput is one pixel per clock while results are taken; from pixel
// accept to result valid an item passes the line store read (s1), the window
// shift (s2), then the median output register. Two stores of MAX_WIDTH words
// hold the previous rows in one dual-word single-port-write memory, read as
// the pixel is accepted; a same-column write/read on consecutive pixels
// (frame_start on column 0) is forwarded. No clearing pass follows reset. A
// stalled result only stalls the stages behind it that are full.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_median_filter_3x3 #(
	parameter int MAX_WIDTH = nmf3_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// config
	input  wire logic                            cfg_wr_en,
	input  wire logic [nmf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nmf3_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel in
	input  wire logic                            pixel_valid,
	output logic                                 pixel_ready,
	input  wire logic [nmf3_pkg::PIX_W-1:0]      red_in,
	input  wire logic [nmf3_pkg::PIX_W-1:0]      green_in,
	input  wire logic [nmf3_pkg::PIX_W-1:0]      blue_in,
	input  wire logic [nmf3_pkg::PIX_W-1:0]      alpha_in,
	input  wire logic                            frame_start,
	// result out
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output logic      [nmf3_pkg::PIX_W-1:0]      red_out,
	output logic      [nmf3_pkg::PIX_W-1:0]      green_out,
	output logic      [nmf3_pkg::PIX_W-1:0]      blue_out,
	output logic      [nmf3_pkg::PIX_W-1:0]      alpha_out,
	output logic      [nmf3_pkg::ROW_W-1:0]      out_row,
	output logic      [nmf3_pkg::COL_OUT_W-1:0]  out_col,
	output logic                                 frame_last
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WW  = nmf3_pkg::WORD_W;
	localparam int PW  = nmf3_pkg::PIX_W;
	localparam int RW  = nmf3_pkg::ROW_W;
	localparam int OCW = nmf3_pkg::COL_OUT_W;
	localparam int NN  = nmf3_pkg::NEIGH_N;

	// handshake / stage control
	logic accept;
	logic en2;       // s1 -> s2 (window shift, line store write)
	logic en3;       // s2 leaves (to output reg when it emits)
	logic s1_valid;
	logic s2_valid;
	logic res_valid_q;

	// s0: position
	logic [AW-1:0]       col0;
	nmf3_pkg::pos_info_t info0;

	// s1
	logic [WW-1:0]       pix_s1;
	logic [AW-1:0]       col_s1;
	nmf3_pkg::pos_info_t info_s1;
	logic                fwd_s1;
	logic [2*WW-1:0]     rd_data;
	logic [WW-1:0]       top_eff;
	logic [WW-1:0]       mid_eff;
	logic [WW-1:0]       fwd_top_q;   // last words written to the stores
	logic [WW-1:0]       fwd_mid_q;
	logic [AW-1:0]       col_m1;

	// s2
	logic [WW-1:0]       win_q [9];
	logic                emit_s2;
	logic                last_s2;
	logic [RW-1:0]       row_s2;
	logic [OCW-1:0]      col_s2;

	// medians
	logic [NN-1:0][PW-1:0] nbr_r;
	logic [NN-1:0][PW-1:0] nbr_g;
	logic [NN-1:0][PW-1:0] nbr_b;
	logic [PW-1:0]         med_r;
	logic [PW-1:0]         med_g;
	logic [PW-1:0]         med_b;

	// ------------------------------------------------------------------
	// Flow control: each stage moves when the one ahead is empty or moving.
	// Items that emit nothing drain from s2 without touching the output.
	// ------------------------------------------------------------------
	assign en3         = s2_valid && (!emit_s2 || !res_valid_q || result_ready);
	assign en2         = s1_valid && (!s2_valid || en3);
	assign pixel_ready = !s1_valid || en2;
	assign accept      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (en2) begin
				s1_valid <= 1'b0;
			end
			if (en2) begin
				s2_valid <= 1'b1;
			end else if (en3) begin
				s2_valid <= 1'b0;
			end
			if (en3 && emit_s2) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// s0: counters and line store read
	// ------------------------------------------------------------------
	nmf3_position #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.frame_start (frame_start),
		.col         (col0),
		.info        (info0)
	);

	nmf3_linebuf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_lbuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col0),
		.rd_data (rd_data),
		.wr_en   (en2),
		.wr_addr (col_s1),
		.wr_data ({mid_eff, pix_s1})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (accept) begin
			// store write of the item leaving s1 lands on this same edge
			fwd_s1 <= en2 && (col0 == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= {alpha_in, blue_in, green_in, red_in};
			col_s1  <= col0;
			info_s1 <= info0;
		end
	end

	// ------------------------------------------------------------------
	// s1: store write, window shift
	// ------------------------------------------------------------------
	assign top_eff = fwd_s1 ? fwd_top_q : rd_data[2*WW-1:WW];
	assign mid_eff = fwd_s1 ? fwd_mid_q : rd_data[WW-1:0];
	assign col_m1  = col_s1 - AW'(1);

	always_ff @(posedge clk) begin
		if (en2) begin
			fwd_top_q <= mid_eff;
			fwd_mid_q <= pix_s1;
			row_s2    <= info_s1.row - RW'(1);
			col_s2    <= OCW'(col_m1);
			last_s2   <= info_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (en2) begin
			emit_s2  <= info_s1.emit;
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= top_eff;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_eff;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= pix_s1;
		end
	end

	// ------------------------------------------------------------------
	// s2: per-channel medians into the output register
	// ------------------------------------------------------------------
	always_comb begin
		for (int k = 0; k < NN; k++) begin
			nbr_r[k] = win_q[nmf3_pkg::NBR_POS[k]][PW-1:0];
			nbr_g[k] = win_q[nmf3_pkg::NBR_POS[k]][2*PW-1:PW];
			nbr_b[k] = win_q[nmf3_pkg::NBR_POS[k]][3*PW-1:2*PW];
		end
	end

	nmf3_median u_med_r (.nbr(nbr_r), .med(med_r));
	nmf3_median u_med_g (.nbr(nbr_g), .med(med_g));
	nmf3_median u_med_b (.nbr(nbr_b), .med(med_b));

	always_ff @(posedge clk) begin
		if (en3 && emit_s2) begin
			red_out    <= med_r;
			green_out  <= med_g;
			blue_out   <= med_b;
			alpha_out  <= win_q[4][4*PW-1:3*PW];
			out_row    <= row_s2;
			out_col    <= col_s2;
			frame_last <= last_s2;
		end
	end

	assign result_valid = res_valid_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !en2 |=> s1_valid)
		else $error("s1 item dropped while stalled");

	a_emit_row: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid && emit_s2 |-> row_s2 != '0)
		else $error("emitting centre on top border row");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		en3 && emit_s2 |=> result_valid)
		else $error("emitting item did not reach output register");

	a_fwd_col: assert property (@(posedge clk) disable iff (!arst_n)
		accept && en2 && (col0 == col_s1) |=> fwd_s1)
		else $error("same-column forward not armed");

endmodule

`default_nettype wire

### tb/median_check_pkg.sv
// ----------------------------------------------------------------------------
// median_check_pkg
// Word types and scoreboard for the 3x3 neighbour median filter bench.
// ----------------------------------------------------------------------------
// The scoreboard mirrors the two line stores, the 3x3 window and the position
// counters, predicts one filtered word per interior centre and compares the
// words that leave the block against those predictions, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

package median_check_pkg;

	localparam int WIN_SLOTS   = 9;
	localparam int CENTRE_SLOT = 4;
	localparam int REPORT_MAX  = 10;

	// packed like the line stores: red in the low byte, alpha in the high byte
	typedef struct packed {
		logic [nmf3_pkg::PIX_W-1:0] alpha;
		logic [nmf3_pkg::PIX_W-1:0] blue;
		logic [nmf3_pkg::PIX_W-1:0] green;
		logic [nmf3_pkg::PIX_W-1:0] red;
	} rgba_t;

	typedef struct packed {
		rgba_t color;
		logic  frame_start;
	} pixel_word_t;

	typedef struct packed {
		logic [nmf3_pkg::PIX_W-1:0]     red;
		logic [nmf3_pkg::PIX_W-1:0]     green;
		logic [nmf3_pkg::PIX_W-1:0]     blue;
		logic [nmf3_pkg::PIX_W-1:0]     alpha;
		logic [nmf3_pkg::ROW_W-1:0]     row;
		logic [nmf3_pkg::COL_OUT_W-1:0] col;
		logic                           last;
	} median_word_t;

	class median_scoreboard;

		int unsigned  width_reg;
		int unsigned  height_reg;
		rgba_t        upper_line [nmf3_pkg::MAX_WIDTH_DEF];
		rgba_t        middle_line [nmf3_pkg::MAX_WIDTH_DEF];
		rgba_t        win [WIN_SLOTS];
		int unsigned  col_cnt;
		int unsigned  row_cnt;
		median_word_t pending_medians [$];
		int unsigned  pixels_seen;
		int unsigned  medians_checked;
		int unsigned  frames_closed;
		int unsigned  mismatches;

		function new();
			width_reg       = nmf3_pkg::WIDTH_RST;
			height_reg      = nmf3_pkg::HEIGHT_RST;
			col_cnt         = 0;
			row_cnt         = 0;
			pixels_seen     = 0;
			medians_checked = 0;
			frames_closed   = 0;
			mismatches      = 0;
			foreach (win[i])
				win[i] = '0;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
		endfunction

		function void write_reg(nmf3_pkg::cfg_reg_t idx,
				logic [nmf3_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				nmf3_pkg::REG_IMAGE_WIDTH:  width_reg  = data[nmf3_pkg::IMG_W_W-1:0];
				nmf3_pkg::REG_IMAGE_HEIGHT: height_reg = data[nmf3_pkg::IMG_H_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned line_width();
			if (width_reg < nmf3_pkg::MIN_SIZE)
				return nmf3_pkg::MIN_SIZE;
			if (width_reg > nmf3_pkg::MAX_WIDTH_DEF)
				return nmf3_pkg::MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int unsigned frame_height();
			return (height_reg < nmf3_pkg::MIN_SIZE) ? nmf3_pkg::MIN_SIZE : height_reg;
		endfunction

		// fifth smallest of the eight window slots around the centre
		function logic [nmf3_pkg::PIX_W-1:0] upper_median(int unsigned lane);
			logic [nmf3_pkg::PIX_W-1:0] v [nmf3_pkg::NEIGH_N];
			logic [nmf3_pkg::PIX_W-1:0] t;
			int                         n;
			n = 0;
			for (int i = 0; i < WIN_SLOTS; i++)
				if (i != CENTRE_SLOT) begin
					v[n] = win[i][lane*nmf3_pkg::PIX_W +: nmf3_pkg::PIX_W];
					n++;
				end
			for (int i = 1; i < nmf3_pkg::NEIGH_N; i++)
				for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
					t      = v[j];
					v[j]   = v[j-1];
					v[j-1] = t;
				end
			return v[nmf3_pkg::MED_RANK];
		endfunction

		function void take_pixel(pixel_word_t p);
			int unsigned  w;
			int unsigned  h;
			int unsigned  c;
			int unsigned  r;
			int unsigned  a;
			rgba_t        top;
			rgba_t        mid;
			median_word_t m;
			w = line_width();
			h = frame_height();
			pixels_seen++;
			if (p.frame_start) begin
				col_cnt = 0;
				row_cnt = 0;
			end
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt++;
			end
			if (row_cnt >= h)
				row_cnt = 0;
			c = col_cnt;
			r = row_cnt;
			a = c % nmf3_pkg::MAX_WIDTH_DEF;

			top = upper_line[a];
			mid = middle_line[a];
			upper_line[a]  = mid;
			middle_line[a] = p.color;

			win[0] = win[1]; win[1] = win[2]; win[2] = top;
			win[3] = win[4]; win[4] = win[5]; win[5] = mid;
			win[6] = win[7]; win[7] = win[8]; win[8] = p.color;

			if (r >= 2 && c >= 2) begin
				m.red   = upper_median(0);
				m.green = upper_median(1);
				m.blue  = upper_median(2);
				m.alpha = win[CENTRE_SLOT].alpha;
				m.row   = nmf3_pkg::ROW_W'(r - 1);
				m.col   = nmf3_pkg::COL_OUT_W'(c - 1);
				m.last  = (r == h - 1) && (c == w - 1);
				pending_medians.push_back(m);
			end

			if (c + 1 >= w) begin
				col_cnt = 0;
				row_cnt = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_cnt = c + 1;
			end
		endfunction

		function void check_median(median_word_t got);
			median_word_t want;
			if (pending_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result word at row %0d col %0d", got.row, got.col);
				return;
			end
			want = pending_medians.pop_front();
			medians_checked++;
			if (want.last)
				frames_closed++;
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
					got.alpha !== want.alpha || got.row !== want.row || got.col !== want.col ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("mismatch: expected rgba %0d %0d %0d %0d row %0d col %0d last %0d",
						want.red, want.green, want.blue, want.alpha, want.row, want.col, want.last);
					$display("          actual   rgba %0d %0d %0d %0d row %0d col %0d last %0d",
						got.red, got.green, got.blue, got.alpha, got.row, got.col, got.last);
				end
			end
		endfunction

	endclass

endpackage

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 neighbour median filter.
// ----------------------------------------------------------------------------
// Pixel words go in raster order with random gaps; result words are taken
// with random stalls and one long hold. Each result is checked in order
// against the scoreboard. A short directed part covers the centre being left
// out, even splits and clamped sizes; then a short run at the widest line
// setting, then random frames, broken frames and noise under many sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT    = 3000;   // cycles with no word moving either way
	localparam int DRAIN_CYCLES  = 8;      // pipeline is three deep, keep a margin
	localparam int HOLD_CYCLES   = 400;    // long receiver hold, fills the pipeline
	localparam int RANDOM_PIXELS = 1500;
	localparam int WIDE_PIXELS   = 64;     // first-row run at the widest setting
	localparam int ROW_CAP       = 8;      // rows sent per frame when height is huge
	localparam int HOLD_PHASE    = 2;

	typedef enum int {
		LEVEL_ANY,
		LEVEL_EXTREME,     // only 0 and 255
		LEVEL_NARROW       // four close values, lots of ties
	} level_style_t;

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             cfg_wr_en    = 1'b0;
	nmf3_pkg::cfg_reg_t               cfg_index    = nmf3_pkg::REG_IMAGE_WIDTH;
	logic [nmf3_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                             pixel_valid  = 1'b0;
	logic                             pixel_ready;
	logic [nmf3_pkg::PIX_W-1:0]       red_in       = '0;
	logic [nmf3_pkg::PIX_W-1:0]       green_in     = '0;
	logic [nmf3_pkg::PIX_W-1:0]       blue_in      = '0;
	logic [nmf3_pkg::PIX_W-1:0]       alpha_in     = '0;
	logic                             frame_start  = 1'b0;
	logic                             result_valid;
	logic                             result_ready = 1'b0;
	logic [nmf3_pkg::PIX_W-1:0]       red_out;
	logic [nmf3_pkg::PIX_W-1:0]       green_out;
	logic [nmf3_pkg::PIX_W-1:0]       blue_out;
	logic [nmf3_pkg::PIX_W-1:0]       alpha_out;
	logic [nmf3_pkg::ROW_W-1:0]       out_row;
	logic [nmf3_pkg::COL_OUT_W-1:0]   out_col;
	logic                             frame_last;

	median_check_pkg::median_scoreboard medians = new();

	// idle controls shared between the driving processes
	int unsigned tx_gap_max = 0;
	int unsigned rx_gap_max = 0;
	int unsigned rx_hold    = 0;
	int unsigned size_settings = 0;

	neighbour_median_filter_3x3 uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [nmf3_pkg::PIX_W-1:0] draw_level(level_style_t style);
		case (style)
			LEVEL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
			LEVEL_NARROW:  return nmf3_pkg::PIX_W'(120 + $urandom_range(0, 3));
			default:       return nmf3_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one pixel word: random gap, then hold valid until the block takes it
	task automatic send_pixel(input median_check_pkg::pixel_word_t p);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		{alpha_in, blue_in, green_in, red_in} <= p.color;
		frame_start <= p.frame_start;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_ready !== 1'b1);
		medians.take_pixel(p);
	endtask

	// marked: frame_start on the first word; noisy: stray frame_start marks inside
	task automatic send_frame(input int unsigned pixels, input bit marked, input bit noisy,
			input level_style_t style);
		median_check_pkg::pixel_word_t p;
		for (int unsigned i = 0; i < pixels; i++) begin
			p.color.red   = draw_level(style);
			p.color.green = draw_level(style);
			p.color.blue  = draw_level(style);
			p.color.alpha = draw_level(style);
			p.frame_start = (i == 0) ? marked : (noisy && $urandom_range(0, 7) == 0);
			send_pixel(p);
		end
	endtask

	// Stop offering, let every expected word come out, then give words that
	// produce nothing time to clear the pipeline before touching the sizes.
	task automatic stop_and_drain();
		pixel_valid <= 1'b0;
		while (medians.pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame_size(input logic [nmf3_pkg::CFG_DATA_W-1:0] w,
			input logic [nmf3_pkg::CFG_DATA_W-1:0] h);
		cfg_wr_en <= 1'b1;
		cfg_index <= nmf3_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		medians.write_reg(nmf3_pkg::REG_IMAGE_WIDTH, w);
		cfg_index <= nmf3_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		medians.write_reg(nmf3_pkg::REG_IMAGE_HEIGHT, h);
		cfg_wr_en <= 1'b0;
		size_settings++;
	endtask

	// Result side. Each word gets a random stall first; a pending hold request
	// replaces that stall once, so the pipeline backs up into the pixel side.
	initial begin : result_sink
		int unsigned                    stall;
		median_check_pkg::median_word_t got;
		forever begin
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end else begin
				stall = $urandom_range(0, rx_gap_max);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid === 1'b1 && result_ready));
			got.red   = red_out;
			got.green = green_out;
			got.blue  = blue_out;
			got.alpha = alpha_out;
			got.row   = out_row;
			got.col   = out_col;
			got.last  = frame_last;
			medians.check_median(got);
		end
	end

	// Ends the run if no word moves on either channel for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pixel_valid && pixel_ready === 1'b1) || (result_valid === 1'b1 && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
		$display("FAIL neighbour_median_filter_3x3");
		$finish;
	end

	initial begin : stimulus
		median_check_pkg::pixel_word_t   p;
		int unsigned                     random_pixels;
		int unsigned                     phase;
		int unsigned                     sel;
		int unsigned                     w;
		int unsigned                     h;
		logic [nmf3_pkg::CFG_DATA_W-1:0] w_cfg;
		logic [nmf3_pkg::CFG_DATA_W-1:0] h_cfg;
		int unsigned                     frame_px;
		int unsigned                     frames;
		int unsigned                     kind;
		int unsigned                     count;
		level_style_t                    style;

		random_pixels = 0;
		phase         = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sizes 0/0 clamp to 3x3: one centre. Neighbours all zero, centre all
		// ones, so the centre must not leak into the median.
		set_frame_size('0, '0);
		for (int i = 0; i < 9; i++) begin
			p.color       = (i == 4) ? '1 : '0;
			p.frame_start = (i == 0);
			send_pixel(p);
		end

		// Widths 2 and height 1 clamp to 3x3. A frame cut short after four
		// words, then a restart with an even split of neighbours: four lows and
		// four highs must give the high value.
		stop_and_drain();
		set_frame_size(16'd2, 16'd1);
		send_frame(4, 1'b1, 1'b0, LEVEL_ANY);
		for (int i = 0; i < 9; i++) begin
			p.color.red   = (i < 4) ? '0 : '1;
			p.color.green = (i < 4) ? '1 : '0;
			p.color.blue  = nmf3_pkg::PIX_W'(i * 31);
			p.color.alpha = nmf3_pkg::PIX_W'(255 - i);
			p.frame_start = (i == 0);
			send_pixel(p);
		end

		// Widest line setting: all-ones width data is masked to 4095 and
		// clamped to the line store depth; a short first-row run gives nothing.
		stop_and_drain();
		set_frame_size('1, 16'd3);
		tx_gap_max = 0;
		rx_gap_max = 1;
		send_frame(WIDE_PIXELS, 1'b1, 1'b0, LEVEL_ANY);

		// Random phases: new idle pattern and frame size each time.
		while (random_pixels < RANDOM_PIXELS) begin
			sel = $urandom_range(0, 3);
			tx_gap_max = (sel == 0) ? 0 : (sel == 1) ? 3 : 19;
			sel = $urandom_range(0, 3);
			rx_gap_max = (sel == 0) ? 0 : (sel == 1) ? 3 : 19;

			sel = $urandom_range(0, 9);
			w = (sel == 0) ? $urandom_range(0, 2) :
				(sel == 1) ? $urandom_range(11, 40) : $urandom_range(3, 10);
			sel = $urandom_range(0, 9);
			h = (sel == 0) ? $urandom_range(0, 2) :
				(sel == 1) ? 65535 : $urandom_range(3, 8);
			// junk in the unused top bits of the width data must be ignored
			w_cfg = {4'($urandom_range(0, 15)), 12'(w)};
			h_cfg = 16'(h);

			// long receiver hold with the sender pushing flat out
			if (phase == HOLD_PHASE) begin
				w_cfg      = 16'd8;
				h_cfg      = 16'd6;
				tx_gap_max = 0;
				rx_gap_max = 0;
			end

			stop_and_drain();
			set_frame_size(w_cfg, h_cfg);
			if (phase == HOLD_PHASE)
				rx_hold = HOLD_CYCLES;

			frame_px = medians.line_width() *
				((medians.frame_height() > ROW_CAP) ? ROW_CAP : medians.frame_height());
			frames = (phase == HOLD_PHASE) ? 2 : $urandom_range(1, 3);
			for (int unsigned f = 0; f < frames; f++) begin
				// mostly whole frames; some cut short, some with stray marks,
				// some running on from the previous frame without a mark
				kind  = (phase == HOLD_PHASE) ? 0 : $urandom_range(0, 9);
				style = level_style_t'($urandom_range(0, 2));
				count = (kind == 7) ? $urandom_range(1, frame_px - 1) : frame_px;
				// the last frame of the run is cut to the pixel budget
				if (count > RANDOM_PIXELS - random_pixels)
					count = RANDOM_PIXELS - random_pixels;
				if (count > 0) begin
					send_frame(count, (f == 0) || (kind != 9), kind == 8, style);
					random_pixels += count;
				end
			end
			phase++;
		end

		stop_and_drain();

		$display("covered %0d pixel words, %0d result words, %0d frames closed, %0d size settings",
			medians.pixels_seen, medians.medians_checked, medians.frames_closed, size_settings);
		$display("sizes from the clamped minimum to the widest setting, stalls, a %0d-cycle hold",
			HOLD_CYCLES);
		if (medians.mismatches == 0 && medians.pending_medians.size() == 0)
			$display("PASS neighbour_median_filter_3x3");
		else
			$display("FAIL neighbour_median_filter_3x3");
		$finish;
	end

endmodule

`default_nettype wire
